// ===== rtl/core/rwmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rwmf_pkg
// shared types and constants of the rgb window median filter
// ----------------------------------------------------------------------------
package rwmf_pkg;

    localparam int PIX_W  = 24;
    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 12;
    localparam int KSIZE_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam int HEIGHT_LIMIT = 2048;
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int HGT_W        = ROW_W + 1;

    localparam logic [KSIZE_W-1:0] RST_KERNEL = 3'd5;
    localparam logic [CFG_W-1:0]   RST_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0]   RST_HEIGHT = 12'd480;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_KERNEL = 7;

    typedef struct packed {
        logic             interior;
        logic             eof;
        logic [PIX_W-1:0] centre;
    } sort_meta_t;

endpackage

// ===== rtl/core/rwmf_line_ram.sv =====
// ----------------------------------------------------------------------------
// rwmf_line_ram
// one row slot of the line store, one write port and two registered reads
// ----------------------------------------------------------------------------
module rwmf_line_ram
    import rwmf_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [PIX_W-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [PIX_W-1:0]         rdata_a,
    output logic [PIX_W-1:0]         rdata_b
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_a_reg;
    logic [PIX_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== rtl/core/rwmf_sort_cell.sv =====
// ----------------------------------------------------------------------------
// rwmf_sort_cell
// one odd or even compare-exchange layer of the transposition sorter
// ----------------------------------------------------------------------------
module rwmf_sort_cell
    import rwmf_pkg::*;
#(
    parameter int N     = 49,
    parameter int PHASE = 0
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      valid_in,
    input  sort_meta_t                meta_in,
    input  logic [N-1:0][PIX_W-1:0]   data_in,
    output logic                      valid_out,
    output sort_meta_t                meta_out,
    output logic [N-1:0][PIX_W-1:0]   data_out
);

    logic                    valid_reg;
    sort_meta_t              meta_reg;
    logic [N-1:0][PIX_W-1:0] data_reg;
    logic [N-1:0][PIX_W-1:0] data_next;

    always_comb
    begin
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] b;
        data_next = data_in;
        for (int j = PHASE; j + 1 < N; j += 2)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                a = data_in[j][c*CH_W +: CH_W];
                b = data_in[j+1][c*CH_W +: CH_W];
                if (a > b)
                begin
                    data_next[j][c*CH_W +: CH_W]   = b;
                    data_next[j+1][c*CH_W +: CH_W] = a;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg <= meta_in;
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign meta_out  = meta_reg;
    assign data_out  = data_reg;

endmodule

// ===== rtl/core/rgb_window_median_filter_core.sv =====
// ----------------------------------------------------------------------------
// rgb_window_median_filter_core
// streaming square-window median filter over rgb pixels in raster order
//
//   channel  signals                         role
//   pix      pix_valid pix_ready kind pixel  pixel or drain transfer in
//   res      res_valid res_ready out_pixel   filtered pixel transfer out
//            end_of_frame
//   cfg      cfg_we cfg_index cfg_data       register write, no wait
//
// one transfer per cycle while pix_ready is high; a result passes through the
// line store read stage, the window load, the sorter chain and the result register
// a pixel transfer yields its result half a window of rows and columns later
// reset and a kernel, width or height register write restart the counters;
// stored pixels are kept; the pipeline stalls as a whole only when the result
// register is held and the last sorter cell is full
// ----------------------------------------------------------------------------
module rgb_window_median_filter_core
    import rwmf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = DEF_MAX_KERNEL
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pix_valid,
    output logic                 pix_ready,
    input  logic                 kind,
    input  logic [PIX_W-1:0]     pixel,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [PIX_W-1:0]     out_pixel,
    output logic                 end_of_frame,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int HALF_MAX = MAX_KERNEL / 2;
    localparam int HALF_W   = $clog2(HALF_MAX + 1);
    localparam int SR       = 2 * HALF_MAX + 1;
    localparam int SLOT_W   = $clog2(SR);
    localparam int NUM_WIN  = SR * SR;
    localparam int IDX_W    = $clog2(NUM_WIN);
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WID_W    = COL_W + 1;
    localparam int LAG_W    = $clog2(HALF_MAX * MAX_WIDTH + HALF_MAX + 1);
    localparam int POS_W    = $clog2(MAX_WIDTH * HEIGHT_LIMIT);

    // configuration
    logic [KSIZE_W-1:0] kernel_size_reg;
    logic [CFG_W-1:0]   frame_width_reg;
    logic [CFG_W-1:0]   frame_height_reg;
    logic               restart;

    logic [WID_W-1:0]  eff_w;
    logic [HGT_W-1:0]  eff_h;
    logic [HALF_W-1:0] half;
    logic [LAG_W-1:0]  lag;

    // stream position
    logic [COL_W-1:0]  col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next;
    logic [POS_W-1:0]  frame_pos_reg, frame_pos_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [LAG_W-1:0]  pending_reg, pending_next;

    logic xfer;
    logic is_pix;
    logic emit;
    logic interior;
    logic eof;
    logic adv;
    logic out_load;

    // stage after the line store read
    logic              s1_shift_reg;
    logic              s1_emit_reg;
    logic [PIX_W-1:0]  s1_pixel_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [SLOT_W-1:0] s1_out_slot_reg;
    logic              s1_interior_reg;
    logic              s1_eof_reg;

    logic [PIX_W-1:0] rd_a [SR];
    logic [PIX_W-1:0] rd_b [SR];

    logic [SR-1:0][SR-1:0][PIX_W-1:0] win_reg;
    logic [SR-1:0][SR-1:0][PIX_W-1:0] win_next;
    logic [SR-1:0][PIX_W-1:0]         column;

    // sorter chain
    logic [NUM_WIN-1:0][PIX_W-1:0] ld_data_next;
    logic                          sv [NUM_WIN+1];
    sort_meta_t                    sm [NUM_WIN+1];
    logic [NUM_WIN-1:0][PIX_W-1:0] sd [NUM_WIN+1];
    logic                          ld_valid_reg;
    sort_meta_t                    ld_meta_reg;
    logic [NUM_WIN-1:0][PIX_W-1:0] ld_data_reg;

    logic [HALF_W:0]       win_side;
    logic [2*HALF_W+1:0]   win_n;
    logic [IDX_W-1:0]      med_idx;
    logic [PIX_W-1:0]      median;

    logic              res_valid_reg;
    logic [PIX_W-1:0]  out_pixel_reg;
    logic              end_of_frame_reg;

    // configuration registers
    assign restart = cfg_we && (cfg_index == REG_KERNEL || cfg_index == REG_WIDTH
                                || cfg_index == REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_size_reg  <= RST_KERNEL;
            frame_width_reg  <= RST_WIDTH;
            frame_height_reg <= RST_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KERNEL: kernel_size_reg  <= cfg_data[KSIZE_W-1:0];
                REG_WIDTH:  frame_width_reg  <= cfg_data;
                REG_HEIGHT: frame_height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        logic [31:0] w32;
        logic [31:0] h32;
        logic [31:0] s32;
        w32 = 32'(frame_width_reg);
        h32 = 32'(frame_height_reg);
        s32 = 32'(kernel_size_reg >> 1);
        if (w32 == 32'd0)
        begin
            w32 = 32'd1;
        end
        else if (w32 > 32'(MAX_WIDTH))
        begin
            w32 = 32'(MAX_WIDTH);
        end
        if (h32 == 32'd0)
        begin
            h32 = 32'd1;
        end
        else if (h32 > 32'(HEIGHT_LIMIT))
        begin
            h32 = 32'(HEIGHT_LIMIT);
        end
        if (s32 > 32'(HALF_MAX))
        begin
            s32 = 32'(HALF_MAX);
        end
        eff_w = WID_W'(w32);
        eff_h = HGT_W'(h32);
        half  = HALF_W'(s32);
        lag   = LAG_W'(s32 * w32 + s32);
    end

    // transfer decision and counters
    assign xfer   = pix_valid && pix_ready;
    assign is_pix = (kind == KIND_PIXEL);

    always_comb
    begin
        if (is_pix)
        begin
            emit = (32'(pending_reg) + 32'd1 > 32'(lag));
        end
        else
        begin
            emit = (pending_reg != '0) && (32'(pending_reg) > 32'(frame_pos_reg));
        end
        interior = (32'(out_row_reg) >= 32'(half))
                && (32'(out_row_reg) + 32'(half) < 32'(eff_h))
                && (32'(out_col_reg) >= 32'(half))
                && (32'(out_col_reg) + 32'(half) < 32'(eff_w));
        eof = (32'(out_row_reg) + 32'd1 >= 32'(eff_h))
           && (32'(out_col_reg) + 32'd1 >= 32'(eff_w));
    end

    always_comb
    begin
        col_cnt_next   = col_cnt_reg;
        row_cnt_next   = row_cnt_reg;
        in_slot_next   = in_slot_reg;
        frame_pos_next = frame_pos_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_slot_next  = out_slot_reg;
        pending_next   = pending_reg;
        if (restart)
        begin
            col_cnt_next   = '0;
            row_cnt_next   = '0;
            in_slot_next   = '0;
            frame_pos_next = '0;
            out_col_next   = '0;
            out_row_next   = '0;
            out_slot_next  = '0;
            pending_next   = '0;
        end
        else if (xfer)
        begin
            if (is_pix)
            begin
                frame_pos_next = frame_pos_reg + 1'b1;
                if (32'(col_cnt_reg) + 32'd1 >= 32'(eff_w))
                begin
                    col_cnt_next = '0;
                    in_slot_next = (in_slot_reg == SLOT_W'(SR - 1)) ? '0
                                                                    : in_slot_reg + 1'b1;
                    if (32'(row_cnt_reg) + 32'd1 >= 32'(eff_h))
                    begin
                        row_cnt_next   = '0;
                        frame_pos_next = '0;
                    end
                    else
                    begin
                        row_cnt_next = row_cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    col_cnt_next = col_cnt_reg + 1'b1;
                end
                if (!emit)
                begin
                    pending_next = pending_reg + 1'b1;
                end
            end
            else if (emit)
            begin
                pending_next = pending_reg - 1'b1;
            end
            if (emit)
            begin
                if (32'(out_col_reg) + 32'd1 >= 32'(eff_w))
                begin
                    out_col_next  = '0;
                    out_slot_next = (out_slot_reg == SLOT_W'(SR - 1)) ? '0
                                                                      : out_slot_reg + 1'b1;
                    out_row_next  = (32'(out_row_reg) + 32'd1 >= 32'(eff_h)) ? '0
                                                                             : out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            in_slot_reg   <= '0;
            frame_pos_reg <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            pending_reg   <= '0;
        end
        else
        begin
            col_cnt_reg   <= col_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            in_slot_reg   <= in_slot_next;
            frame_pos_reg <= frame_pos_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_slot_reg  <= out_slot_next;
            pending_reg   <= pending_next;
        end
    end

    // line store, one memory per row slot
    for (genvar g = 0; g < SR; g++)
    begin : g_slot
        rwmf_line_ram #(
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .clk     (clk),
            .rd_en   (adv),
            .we      (xfer && is_pix && (in_slot_reg == SLOT_W'(g))),
            .waddr   (col_cnt_reg),
            .wdata   (pixel),
            .raddr_a (col_cnt_reg),
            .raddr_b (out_col_reg),
            .rdata_a (rd_a[g]),
            .rdata_b (rd_b[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_shift_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_shift_reg <= xfer && is_pix;
            s1_emit_reg  <= xfer && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pixel_reg    <= pixel;
            s1_slot_reg     <= in_slot_reg;
            s1_out_slot_reg <= out_slot_reg;
            s1_interior_reg <= interior;
            s1_eof_reg      <= eof;
        end
    end

    // window column cells shift by one column per pixel
    always_comb
    begin
        logic [SLOT_W-1:0] sidx;
        column[0] = s1_pixel_reg;
        for (int k = 1; k < SR; k++)
        begin
            if (s1_slot_reg >= SLOT_W'(k))
            begin
                sidx = s1_slot_reg - SLOT_W'(k);
            end
            else
            begin
                sidx = SLOT_W'(32'(s1_slot_reg) + SR - k);
            end
            column[k] = rd_a[sidx];
        end
        win_next = win_reg;
        if (s1_shift_reg)
        begin
            win_next[0] = column;
            for (int i = 1; i < SR; i++)
            begin
                win_next[i] = win_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            win_reg <= win_next;
        end
    end

    // cells outside the active window load as zero
    always_comb
    begin
        for (int i = 0; i < SR; i++)
        begin
            for (int k = 0; k < SR; k++)
            begin
                if (32'(i) <= 32'(half) * 2 && 32'(k) <= 32'(half) * 2)
                begin
                    ld_data_next[i*SR + k] = win_next[i][k];
                end
                else
                begin
                    ld_data_next[i*SR + k] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ld_valid_reg <= s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ld_meta_reg.interior <= s1_interior_reg;
            ld_meta_reg.eof      <= s1_eof_reg;
            ld_meta_reg.centre   <= rd_b[s1_out_slot_reg];
            ld_data_reg          <= ld_data_next;
        end
    end

    assign sv[0] = ld_valid_reg;
    assign sm[0] = ld_meta_reg;
    assign sd[0] = ld_data_reg;

    for (genvar g = 0; g < NUM_WIN; g++)
    begin : g_cell
        rwmf_sort_cell #(
            .N     (NUM_WIN),
            .PHASE (g % 2)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (sv[g]),
            .meta_in   (sm[g]),
            .data_in   (sd[g]),
            .valid_out (sv[g+1]),
            .meta_out  (sm[g+1]),
            .data_out  (sd[g+1])
        );
    end

    // pick the middle of the real values above the zero padding
    always_comb
    begin
        win_side = {half, 1'b1};
        win_n    = (2*HALF_W+2)'(win_side) * (2*HALF_W+2)'(win_side);
        med_idx  = IDX_W'(NUM_WIN - 32'((win_n + 1'b1) >> 1));
        median   = sd[NUM_WIN][med_idx];
    end

    assign out_load  = !res_valid_reg || res_ready;
    assign adv       = out_load || !sv[NUM_WIN];
    assign pix_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= sv[NUM_WIN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && sv[NUM_WIN])
        begin
            out_pixel_reg    <= sm[NUM_WIN].interior ? median : sm[NUM_WIN].centre;
            end_of_frame_reg <= sm[NUM_WIN].eof;
        end
    end

    assign res_valid    = res_valid_reg;
    assign out_pixel    = out_pixel_reg;
    assign end_of_frame = end_of_frame_reg;

    // pending never runs past the window lag
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(pending_reg) <= 32'(lag))
        else $error("pending count above lag");

    // input column stays inside the row
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_cnt_reg) < 32'(eff_w))
        else $error("column count out of row");

    // frame position tracks row and column
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(frame_pos_reg) == 32'(row_cnt_reg) * 32'(eff_w) + 32'(col_cnt_reg))
        else $error("frame position out of step");

    // a drain only ever flushes edge pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && kind == KIND_DRAIN && emit && half != '0) |-> !interior)
        else $error("drain flushed an interior pixel");

endmodule
